[src/dqb_pkg.sv]
// ----------------------------------------------------------------------------
// dqb_pkg
// Shared types and constants of the DNS query builder: message byte codes,
// input operation codes, register indexes and the front-to-back command.
// ----------------------------------------------------------------------------
package dqb_pkg;

   // Default label length limit and width of the label length field
   localparam int LABEL_MAX_DEF = 32;
   localparam int LEN_W         = 6;

   // Command queue depth between front and back
   localparam int FIFO_DEPTH = 4;

   // Byte sequencer step counter
   localparam int STEP_W     = 4;
   localparam int HDR_BYTES  = 12;
   localparam int TAIL_BYTES = 5;

   // Input operation codes
   localparam logic OP_CHAR = 1'b0;
   localparam logic OP_END  = 1'b1;

   localparam logic [7:0] DOT_CHAR = 8'h2E;

   // Fixed message bytes
   localparam logic [7:0] FLAGS_HI    = 8'h01;
   localparam logic [7:0] QDCOUNT_LO  = 8'h01;
   localparam logic [7:0] CLASS_IN_LO = 8'h01;
   localparam logic [7:0] ZERO_BYTE   = 8'h00;

   // Configuration registers
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_QUERY_ID   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUERY_TYPE = 1'd1;
   localparam logic [15:0] QUERY_ID_RST   = 16'h474C;
   localparam logic [7:0]  QUERY_TYPE_RST = 8'h01;

   // One command per item that produces bytes
   typedef struct packed {
      logic             hdr;   // emit the 12-byte header first
      logic [LEN_W-1:0] len;   // label length to flush, zero for none
      logic             tail;  // emit root, type and class
      logic             ovf;   // label overflow flag to report
   } cmd_type;

endpackage

[src/dqb_front.sv]
// ----------------------------------------------------------------------------
// dqb_front
// Accepts name items, buffers label characters into the back's label store
// and queues one command per item that produces message bytes.
// ----------------------------------------------------------------------------
module dqb_front #(
   parameter int LABEL_MAX = dqb_pkg::LABEL_MAX_DEF,
   parameter int IDX_W     = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_operation,
   input  logic [7:0]       req_name_char,
   output logic             push,
   output dqb_pkg::cmd_type cmd,
   input  logic             fifo_full,
   input  logic             flush_done,
   output logic             wr_en,
   output logic [IDX_W-1:0] wr_addr,
   output logic [7:0]       wr_data
);
   import dqb_pkg::*;

   localparam int CNT_W = $clog2(LABEL_MAX + 1);

   logic             header_sent_ff, header_sent_in;
   logic [CNT_W-1:0] label_count_ff, label_count_in;
   logic             overflow_ff, overflow_in;
   logic             busy_ff, busy_in;

   logic is_end, is_dot, has_room, need_write, accept;

   assign is_end     = (req_operation == OP_END);
   assign is_dot     = (req_operation == OP_CHAR) && (req_name_char == DOT_CHAR);
   assign has_room   = (label_count_ff < CNT_W'(LABEL_MAX));
   assign need_write = (req_operation == OP_CHAR) && !is_dot && has_room;

   // hold characters back while the back still reads the previous label, and hold every item while the queue is full
   assign req_stall = fifo_full || (busy_ff && need_write);
   assign accept    = req_valid && !req_stall;

   assign wr_en   = accept && need_write;
   assign wr_addr = label_count_ff[IDX_W-1:0];
   assign wr_data = req_name_char;

   always_comb begin
      cmd.hdr  = !header_sent_ff;
      cmd.len  = (is_end || is_dot) ? LEN_W'(label_count_ff) : '0;
      cmd.tail = is_end;
      cmd.ovf  = overflow_ff;
   end

   assign push = accept && (cmd.hdr || cmd.tail || (cmd.len != '0));

   always_comb begin
      header_sent_in = header_sent_ff;
      label_count_in = label_count_ff;
      overflow_in    = overflow_ff;
      busy_in        = busy_ff && !flush_done;
      if (accept) begin
         header_sent_in = !is_end;
         if (is_end || is_dot) begin
            label_count_in = '0;
         end else if (has_room) begin
            label_count_in = label_count_ff + CNT_W'(1);
         end
         if (is_end) begin
            overflow_in = 1'b0;
         end else if (!is_dot && !has_room) begin
            overflow_in = 1'b1;
         end
         if (push && (cmd.len != '0)) begin
            busy_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_sent_ff <= 1'b0;
         label_count_ff <= '0;
         overflow_ff    <= 1'b0;
         busy_ff        <= 1'b0;
      end else begin
         header_sent_ff <= header_sent_in;
         label_count_ff <= label_count_in;
         overflow_ff    <= overflow_in;
         busy_ff        <= busy_in;
      end
   end

   a_no_write_while_busy : assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !busy_ff)
      else $error("label store written while a flush is still reading it");

   a_count_bounded : assert property (@(posedge clock) disable iff (reset)
      label_count_ff <= CNT_W'(LABEL_MAX))
      else $error("label count beyond label limit");

endmodule

[src/dqb_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// dqb_cmd_fifo
// Short command queue that decouples the front from the byte sequencer.
// ----------------------------------------------------------------------------
module dqb_cmd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  dqb_pkg::cmd_type cmd_in,
   input  logic             pop,
   output dqb_pkg::cmd_type head,
   output logic             full,
   output logic             empty
);
   import dqb_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   cmd_type          slot_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == CNT_W'(FIFO_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   a_no_overrun : assert property (@(posedge clock) disable iff (reset)
      (push |-> !full) and (pop |-> !empty))
      else $error("command queue overrun or underrun");

endmodule

[src/dqb_back.sv]
// ----------------------------------------------------------------------------
// dqb_back
// Byte sequencer: runs one command at a time, emitting header, label and
// tail bytes through a registered output stage. Holds the label store.
// ----------------------------------------------------------------------------
module dqb_back #(
   parameter int LABEL_MAX = dqb_pkg::LABEL_MAX_DEF,
   parameter int IDX_W     = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             fifo_empty,
   input  dqb_pkg::cmd_type fifo_head,
   output logic             pop,
   output logic             flush_done,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [7:0]       wr_data,
   input  logic [15:0]      query_id,
   input  logic [7:0]       query_type,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last,
   output logic             rsp_label_overflow
);
   import dqb_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_HDR  = 6'b000010,
      ST_LEN  = 6'b000100,
      ST_LRD  = 6'b001000,
      ST_LCH  = 6'b010000,
      ST_TAIL = 6'b100000
   } bk_state_type;

   bk_state_type      state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       ovf_ff, ovf_in;

   logic [7:0] store_mem [LABEL_MAX];
   logic [7:0] rd_data_ff;

   logic       adv, idx_last, hdr_last, tail_last;
   logic [7:0] hdr_byte, tail_byte;

   // label store: one write port from the front, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_mem[idx_ff];
   end

   assign adv       = !valid_ff || !rsp_stall;
   assign idx_last  = ((LEN_W'(idx_ff) + LEN_W'(1)) == cmd_ff.len);
   assign hdr_last  = (step_ff == STEP_W'(HDR_BYTES - 1));
   assign tail_last = (step_ff == STEP_W'(TAIL_BYTES - 1));

   always_comb begin
      case (step_ff)
         4'd0:    hdr_byte = query_id[15:8];
         4'd1:    hdr_byte = query_id[7:0];
         4'd2:    hdr_byte = FLAGS_HI;
         4'd5:    hdr_byte = QDCOUNT_LO;
         default: hdr_byte = ZERO_BYTE;
      endcase
   end

   always_comb begin
      case (step_ff)
         4'd2:    tail_byte = query_type;
         4'd4:    tail_byte = CLASS_IN_LO;
         default: tail_byte = ZERO_BYTE;
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      step_in    = step_ff;
      idx_in     = idx_ff;
      pop        = 1'b0;
      flush_done = 1'b0;
      valid_in   = valid_ff && rsp_stall;
      byte_in    = byte_ff;
      last_in    = last_ff;
      ovf_in     = ovf_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!fifo_empty) begin
               pop     = 1'b1;
               cmd_in  = fifo_head;
               step_in = '0;
               if (fifo_head.hdr) begin
                  state_in = ST_HDR;
               end else if (fifo_head.len != '0) begin
                  state_in = ST_LEN;
               end else if (fifo_head.tail) begin
                  state_in = ST_TAIL;
               end
            end
         end
         ST_HDR: begin
            if (adv) begin
               valid_in = 1'b1;
               byte_in  = hdr_byte;
               last_in  = 1'b0;
               ovf_in   = cmd_ff.ovf;
               if (hdr_last) begin
                  step_in = '0;
                  if (cmd_ff.len != '0) begin
                     state_in = ST_LEN;
                  end else if (cmd_ff.tail) begin
                     state_in = ST_TAIL;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  step_in = step_ff + STEP_W'(1);
               end
            end
         end
         ST_LEN: begin
            if (adv) begin
               valid_in = 1'b1;
               byte_in  = 8'(cmd_ff.len);
               last_in  = 1'b0;
               ovf_in   = cmd_ff.ovf;
               idx_in   = '0;
               state_in = ST_LRD;
            end
         end
         ST_LRD: begin
            state_in = ST_LCH;
         end
         ST_LCH: begin
            if (adv) begin
               valid_in = 1'b1;
               byte_in  = rd_data_ff;
               last_in  = 1'b0;
               ovf_in   = cmd_ff.ovf;
               if (idx_last) begin
                  flush_done = 1'b1;
                  idx_in     = '0;
                  state_in   = cmd_ff.tail ? ST_TAIL : ST_IDLE;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = ST_LRD;
               end
            end
         end
         ST_TAIL: begin
            if (adv) begin
               valid_in = 1'b1;
               byte_in  = tail_byte;
               last_in  = tail_last;
               ovf_in   = cmd_ff.ovf;
               if (tail_last) begin
                  step_in  = '0;
                  state_in = ST_IDLE;
               end else begin
                  step_in = step_ff + STEP_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
      ovf_ff  <= ovf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_out_byte       = byte_ff;
   assign rsp_last           = last_ff;
   assign rsp_label_overflow = ovf_ff;

   a_last_is_class : assert property (@(posedge clock) disable iff (reset)
      (valid_ff && last_ff) |-> (byte_ff == CLASS_IN_LO))
      else $error("final byte is not the class low byte");

   a_len_nonzero : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LEN) |-> (cmd_ff.len != '0))
      else $error("empty label reached the length byte");

endmodule

[src/dns_query_builder_top.sv]
// ----------------------------------------------------------------------------
// dns_query_builder_top
// DNS query builder: turns a dotted domain name into a query message.
//
// Usage: send the name one character per req item (req_operation = char),
// then one end item (req_operation = end, req_name_char ignored). The rsp
// channel returns the message one byte per item: the 12-byte header with
// csr query ID, the labels as length byte plus characters, then the root
// byte, query type and class IN; rsp_last marks the final byte and
// rsp_label_overflow reports a label cut at LABEL_MAX within this name.
// Header, length and tail bytes leave one per cycle while rsp_stall is low;
// each label character passes through a read state (ST_LRD) and then an
// output state (ST_LCH), set by the registered read of the label store.
// Characters are stored one per cycle while req_stall is low; a new label's
// characters are held off (req_stall) until the previous label has been read
// out of the store; every item is held off while the command queue is full.
// Reset clears all control state and loads the register defaults; the label
// store needs no clearing. While rsp_valid and rsp_stall are high the output
// byte holds and the sequencer waits; the command queue keeps input running.
// ----------------------------------------------------------------------------
module dns_query_builder_top #(
   parameter int LABEL_MAX = dqb_pkg::LABEL_MAX_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_operation,
   input  logic [7:0]                      req_name_char,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [7:0]                      rsp_out_byte,
   output logic                            rsp_last,
   output logic                            rsp_label_overflow,
   input  logic                            csr_wr_en,
   input  logic [dqb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dqb_pkg::CSR_DATA_W-1:0]  csr_wr_data
);
   import dqb_pkg::*;

   localparam int IDX_W = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;

   logic [15:0] query_id_ff;
   logic [7:0]  query_type_ff;

   logic             push, pop, fifo_full, fifo_empty, flush_done;
   cmd_type          front_cmd, fifo_head;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [7:0]       wr_data;

   // configuration registers: written only while idle by user; not enforced
   always_ff @(posedge clock) begin
      if (reset) begin
         query_id_ff   <= QUERY_ID_RST;
         query_type_ff <= QUERY_TYPE_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_QUERY_ID:   query_id_ff   <= csr_wr_data;
            CSR_QUERY_TYPE: query_type_ff <= csr_wr_data[7:0];
            default: ;
         endcase
      end
   end

   // front: classify items, buffer label characters, queue commands
   dqb_front #(
      .LABEL_MAX (LABEL_MAX),
      .IDX_W     (IDX_W)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_name_char (req_name_char),
      .push          (push),
      .cmd           (front_cmd),
      .fifo_full     (fifo_full),
      .flush_done    (flush_done),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data)
   );

   // queue: lets the front run ahead of the byte sequencer
   dqb_cmd_fifo u_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .cmd_in (front_cmd),
      .pop    (pop),
      .head   (fifo_head),
      .full   (fifo_full),
      .empty  (fifo_empty)
   );

   // back: advance through header, labels and tail one byte at a time
   dqb_back #(
      .LABEL_MAX (LABEL_MAX),
      .IDX_W     (IDX_W)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .fifo_empty         (fifo_empty),
      .fifo_head          (fifo_head),
      .pop                (pop),
      .flush_done         (flush_done),
      .wr_en              (wr_en),
      .wr_addr            (wr_addr),
      .wr_data            (wr_data),
      .query_id           (query_id_ff),
      .query_type         (query_type_ff),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_last           (rsp_last),
      .rsp_label_overflow (rsp_label_overflow)
   );

endmodule
